[design/ccfd_pkg.sv]
// ----------------------------------------------------------------------------
// ccfd_pkg: shared types and constants of the checked frame deframer
// Result codes, frame layout constants, the result record and the bytewise
// CRC-16/X.25 update.
// ----------------------------------------------------------------------------
package ccfd_pkg;

   // Frame layout
   localparam int HEADER_BYTES   = 16;
   localparam int OVERHEAD_BYTES = 18;
   localparam int HDR_DEPTH      = 13;   // header bytes 1..13 kept as bytes
   localparam int HDR_IDX_W      = 4;
   localparam int LEN_HI_POS     = 14;
   localparam int LEN_LO_POS     = 15;

   // Byte counter
   localparam int               POS_W   = 17;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // CRC-16/X.25, reflected form
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;

   localparam logic [7:0] START_MARKER_RESET = 8'hF2;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef enum logic {
      KIND_BODY   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_BAD_START = 2'd2,
      STATUS_CRC_ERROR = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  body_byte;
      status_type  frame_status;
      logic [7:0]  proto_version;
      logic [7:0]  proto_type;
      logic [15:0] command_word;
      logic [47:0] station_address;
      logic [15:0] device_class;
      logic [7:0]  reserved_byte;
      logic [15:0] body_length;
   } result_type;

   // One byte through the CRC, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[design/ccfd_if.sv]
// ----------------------------------------------------------------------------
// ccfd channel interfaces
// Byte channel into the deframer and result channel out of it, both with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface ccfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  body_byte;
   logic [1:0]  frame_status;
   logic [7:0]  proto_version;
   logic [7:0]  proto_type;
   logic [15:0] command_word;
   logic [47:0] station_address;
   logic [15:0] device_class;
   logic [7:0]  reserved_byte;
   logic [15:0] body_length;

   modport source (output valid, output result_kind, output body_byte,
                   output frame_status, output proto_version, output proto_type,
                   output command_word, output station_address,
                   output device_class, output reserved_byte,
                   output body_length, input ready);
   modport sink   (input valid, input result_kind, input body_byte,
                   input frame_status, input proto_version, input proto_type,
                   input command_word, input station_address,
                   input device_class, input reserved_byte,
                   input body_length, output ready);
endinterface

[design/crc_checked_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer_unit: CRC-16/X.25 checked frame parser
// Usage:
//   req_chan carries the received buffer one byte per item, with buffer_end
//   set on the last byte. Byte 0 is checked against the start marker held in
//   the csr register (written via csr_wr_en/csr_wr_data, reset 0xF2); bytes
//   1..15 form the header; body bytes follow and the two check bytes close
//   the frame. Bytes after the check bytes are dropped until buffer_end.
//   rsp_chan gives a body item per body byte (none when the start byte is bad)
//   and one status item on each buffer_end, with the header fields for an OK or
//   CRC-error status; a body byte that is also the last byte gives both, body first.
// Timing:
//   One byte per cycle is taken while req_chan.ready is high. The per-byte work
//   (bytewise CRC update, counter, header capture) sits between the state
//   registers and a 4-entry result queue, so each result is registered in the queue.
//   req_chan.ready is high while the queue holds at most 2 results; a stalled
//   receiver fills the queue and then holds off the sender.
// Reset:
//   Synchronous, active high: queue emptied, frame state restarted, start
//   marker back to 0xF2. Header byte storage is not cleared.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   ccfd_req_if.sink   req_chan,
   ccfd_rsp_if.source rsp_chan
);
   import ccfd_pkg::*;

   // Frame state
   logic [7:0]       marker_ff;
   logic [POS_W-1:0] pos_ff, pos_in, pos_step;
   logic [15:0]      len_ff, len_in, len_step;
   logic [15:0]      crc_ff, crc_in, crc_step;
   logic             bad_ff, bad_in, bad_step;
   logic             fin_ff, fin_in, fin_step;
   logic [7:0]       hdr_ff [HDR_DEPTH];

   // Result queue
   result_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FIFO_AW:0]   count_ff, count_in;

   logic             accept, pop;
   logic [POS_W-1:0] body_end;
   logic             in_header, in_body, hdr_wr;
   logic             body_valid, status_valid;
   logic [17:0]      need_count;
   status_type       status;
   result_type       body_res, stat_res;
   logic [HDR_IDX_W-1:0] hdr_idx;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

   // Frame position decode
   assign body_end  = POS_W'(HEADER_BYTES) + {1'b0, len_ff};
   assign in_header = (pos_ff != '0) && (pos_ff < POS_W'(HEADER_BYTES));
   assign in_body   = !in_header && (pos_ff != '0) && (pos_ff < body_end);
   assign hdr_wr    = accept && !fin_ff && (pos_ff != '0) &&
                      (pos_ff <= POS_W'(HDR_DEPTH));
   assign hdr_idx   = pos_ff[HDR_IDX_W-1:0] - HDR_IDX_W'(1);

   // Per-byte step
   always_comb begin
      pos_step = pos_ff;
      len_step = len_ff;
      crc_step = crc_ff;
      bad_step = bad_ff;
      fin_step = fin_ff;
      if (!fin_ff) begin
         if (pos_ff == '0) begin
            bad_step = (req_chan.rx_byte != marker_ff);
         end else begin
            crc_step = crc_byte(crc_ff, req_chan.rx_byte);
            if (pos_ff == POS_W'(LEN_HI_POS)) begin
               len_step[15:8] = req_chan.rx_byte;
            end
            if (pos_ff == POS_W'(LEN_LO_POS)) begin
               len_step[7:0] = req_chan.rx_byte;
            end
            if (!in_header && !in_body && (pos_ff == body_end + POS_W'(1))) begin
               fin_step = 1'b1;
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_step = pos_ff + POS_W'(1);
         end
      end
   end

   // Status decision on the last byte
   assign need_count = {2'b00, len_step} + 18'(OVERHEAD_BYTES);
   always_comb begin
      if (pos_step < POS_W'(OVERHEAD_BYTES)) begin
         status = STATUS_SHORT;
      end else if (bad_step) begin
         status = STATUS_BAD_START;
      end else if ({1'b0, pos_step} < need_count) begin
         status = STATUS_SHORT;
      end else if (crc_step == CRC_RESIDUE) begin
         status = STATUS_OK;
      end else begin
         status = STATUS_CRC_ERROR;
      end
   end

   assign body_valid   = accept && !fin_ff && in_body && !bad_ff;
   assign status_valid = accept && req_chan.buffer_end;

   // Result records
   always_comb begin
      body_res             = '0;
      body_res.result_kind = KIND_BODY;
      body_res.body_byte   = req_chan.rx_byte;

      stat_res              = '0;
      stat_res.result_kind  = KIND_STATUS;
      stat_res.frame_status = status;
      if ((status == STATUS_OK) || (status == STATUS_CRC_ERROR)) begin
         stat_res.proto_version   = hdr_ff[0];
         stat_res.proto_type      = hdr_ff[1];
         stat_res.command_word    = {hdr_ff[2], hdr_ff[3]};
         stat_res.station_address = {hdr_ff[4], hdr_ff[5], hdr_ff[6],
                                     hdr_ff[7], hdr_ff[8], hdr_ff[9]};
         stat_res.device_class    = {hdr_ff[10], hdr_ff[11]};
         stat_res.reserved_byte   = hdr_ff[12];
         stat_res.body_length     = len_step;
      end
   end

   // Next frame state: restart after the last byte
   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      bad_in = bad_ff;
      fin_in = fin_ff;
      if (accept) begin
         if (req_chan.buffer_end) begin
            pos_in = '0;
            len_in = '0;
            crc_in = CRC_INIT;
            bad_in = 1'b0;
            fin_in = 1'b0;
         end else begin
            pos_in = pos_step;
            len_in = len_step;
            crc_in = crc_step;
            bad_in = bad_step;
            fin_in = fin_step;
         end
      end
   end

   // Queue pointers
   always_comb begin
      tail_in  = tail_ff + FIFO_AW'(body_valid) + FIFO_AW'(status_valid);
      head_in  = head_ff + FIFO_AW'(pop);
      count_in = count_ff + (FIFO_AW+1)'(body_valid) + (FIFO_AW+1)'(status_valid)
                 - (FIFO_AW+1)'(pop);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= START_MARKER_RESET;
         pos_ff    <= '0;
         len_ff    <= '0;
         crc_ff    <= CRC_INIT;
         bad_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         bad_ff   <= bad_in;
         fin_ff   <= fin_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Header bytes and result queue storage
   always_ff @(posedge clock) begin
      if (hdr_wr) begin
         hdr_ff[hdr_idx] <= req_chan.rx_byte;
      end
      if (body_valid) begin
         fifo_ff[tail_ff] <= body_res;
      end
      if (status_valid) begin
         fifo_ff[tail_ff + FIFO_AW'(body_valid)] <= stat_res;
      end
   end

   // Result channel
   assign rsp_chan.valid           = (count_ff != '0);
   assign rsp_chan.result_kind     = fifo_ff[head_ff].result_kind;
   assign rsp_chan.body_byte       = fifo_ff[head_ff].body_byte;
   assign rsp_chan.frame_status    = fifo_ff[head_ff].frame_status;
   assign rsp_chan.proto_version   = fifo_ff[head_ff].proto_version;
   assign rsp_chan.proto_type      = fifo_ff[head_ff].proto_type;
   assign rsp_chan.command_word    = fifo_ff[head_ff].command_word;
   assign rsp_chan.station_address = fifo_ff[head_ff].station_address;
   assign rsp_chan.device_class    = fifo_ff[head_ff].device_class;
   assign rsp_chan.reserved_byte   = fifo_ff[head_ff].reserved_byte;
   assign rsp_chan.body_length     = fifo_ff[head_ff].body_length;

`ifndef SYNTHESIS
   // Queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("result queue overflow");

   // An item is only taken with room for two results
   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2)))
      else $error("item taken without queue room");

   // Reset leaves an empty queue and a fresh frame
   a_reset_state: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && (pos_ff == '0) && (crc_ff == CRC_INIT))
      else $error("state not restarted by reset");

   // A finished frame has seen at least the full overhead
   a_finished_len: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> (pos_ff >= POS_W'(OVERHEAD_BYTES)))
      else $error("frame finished too early");

   // A body result never comes from a frame with a bad start byte
   a_no_body_bad: assert property (@(posedge clock) disable iff (reset)
      bad_ff |-> !body_valid)
      else $error("body passed on for bad start");
`endif

endmodule

[dv/ccfd_frame_checker.sv]
// ----------------------------------------------------------------------------
// ccfd_frame_checker: result checker for the checked frame deframer
// Watches the byte channel, the result channel and the start marker register.
// Every accepted byte goes through a local deframer model. Each body item and
// status item it yields is queued, and each accepted result item is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ccfd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   ccfd_req_if         req_mon,
   ccfd_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned results_owed
);
   import ccfd_pkg::*;

   localparam int unsigned MAX_REPORTS = 100;

   // Model state
   logic [7:0]       marker;
   logic [POS_W-1:0] byte_pos;
   logic [15:0]      decl_len;
   logic [7:0]       hdr_bytes [HDR_DEPTH];
   logic [15:0]      crc_acc;
   logic             bad_start;
   logic             trailer_done;

   result_type  expected_q[$];
   int unsigned reports;

   // CRC-16/X.25, one data bit at a time, LSB first
   function automatic logic [15:0] crc_shift(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c  = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   task automatic restart_frame();
      byte_pos     = '0;
      decl_len     = '0;
      crc_acc      = CRC_INIT;
      bad_start    = 1'b0;
      trailer_done = 1'b0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
   endtask

   // Advance the model by one byte; queue whatever results it produces
   task automatic deframe_byte(input logic [7:0] b, input logic is_end);
      logic [POS_W-1:0] body_end;
      logic [POS_W-1:0] need;
      result_type       r;
      if (!trailer_done) begin
         body_end = POS_W'(HEADER_BYTES) + POS_W'(decl_len);
         if (byte_pos == 0) begin
            bad_start = (b != marker);
         end else begin
            crc_acc = crc_shift(crc_acc, b);
            if (byte_pos <= HDR_DEPTH) begin
               hdr_bytes[byte_pos - 1] = b;
            end else if (byte_pos == LEN_HI_POS) begin
               decl_len[15:8] = b;
            end else if (byte_pos == LEN_LO_POS) begin
               decl_len[7:0] = b;
            end else if (byte_pos < body_end) begin
               // body bytes of a frame with a bad start are dropped
               if (!bad_start) begin
                  r             = '0;
                  r.result_kind = KIND_BODY;
                  r.body_byte   = b;
                  expected_q.push_back(r);
               end
            end else if (byte_pos == body_end + 1) begin
               trailer_done = 1'b1;
            end
         end
         if (byte_pos != POS_MAX) byte_pos++;
      end

      // Status on the last byte of the buffer
      if (is_end) begin
         need          = POS_W'(OVERHEAD_BYTES) + POS_W'(decl_len);
         r             = '0;
         r.result_kind = KIND_STATUS;
         if (byte_pos < OVERHEAD_BYTES) r.frame_status = STATUS_SHORT;
         else if (bad_start)            r.frame_status = STATUS_BAD_START;
         else if (byte_pos < need)      r.frame_status = STATUS_SHORT;
         else if (crc_acc == CRC_RESIDUE) r.frame_status = STATUS_OK;
         else                           r.frame_status = STATUS_CRC_ERROR;
         if (r.frame_status == STATUS_OK || r.frame_status == STATUS_CRC_ERROR) begin
            r.proto_version   = hdr_bytes[0];
            r.proto_type      = hdr_bytes[1];
            r.command_word    = {hdr_bytes[2], hdr_bytes[3]};
            r.station_address = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6],
                                 hdr_bytes[7], hdr_bytes[8], hdr_bytes[9]};
            r.device_class    = {hdr_bytes[10], hdr_bytes[11]};
            r.reserved_byte   = hdr_bytes[12];
            r.body_length     = decl_len;
         end
         expected_q.push_back(r);
         restart_frame();
      end
   endtask

   function automatic bit field_differs(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
      if (want === got) return 1'b0;
      if (reports < MAX_REPORTS)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      reports++;
      return 1'b1;
   endfunction

   // Predict on accepted bytes, compare accepted result items
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      bit         bad;
      if (reset) begin
         marker = START_MARKER_RESET;
         restart_frame();
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            deframe_byte(req_mon.rx_byte, req_mon.buffer_end);

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.result_kind     = kind_type'(rsp_mon.result_kind);
            seen.body_byte       = rsp_mon.body_byte;
            seen.frame_status    = status_type'(rsp_mon.frame_status);
            seen.proto_version   = rsp_mon.proto_version;
            seen.proto_type      = rsp_mon.proto_type;
            seen.command_word    = rsp_mon.command_word;
            seen.station_address = rsp_mon.station_address;
            seen.device_class    = rsp_mon.device_class;
            seen.reserved_byte   = rsp_mon.reserved_byte;
            seen.body_length     = rsp_mon.body_length;
            if (expected_q.size() == 0) begin
               if (reports < MAX_REPORTS)
                  $display("%0t: unexpected result item, expected none, actual %p",
                           $time, seen);
               reports++;
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               bad  = 1'b0;
               bad |= field_differs("result_kind", want.result_kind, seen.result_kind);
               bad |= field_differs("body_byte", want.body_byte, seen.body_byte);
               bad |= field_differs("frame_status", want.frame_status, seen.frame_status);
               bad |= field_differs("proto_version", want.proto_version, seen.proto_version);
               bad |= field_differs("proto_type", want.proto_type, seen.proto_type);
               bad |= field_differs("command_word", want.command_word, seen.command_word);
               bad |= field_differs("station_address", want.station_address,
                                    seen.station_address);
               bad |= field_differs("device_class", want.device_class, seen.device_class);
               bad |= field_differs("reserved_byte", want.reserved_byte, seen.reserved_byte);
               bad |= field_differs("body_length", want.body_length, seen.body_length);
               if (bad) fail_count++;
            end
         end

         if (csr_wr_en) marker = csr_wr_data;
      end
      results_owed = expected_q.size();
   end

endmodule

[dv/tb_crc_checked_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// tb_crc_checked_frame_deframer_unit: testbench for the checked frame deframer
// Feeds received buffers byte by byte: a few directed buffers, then random
// frames, mostly well formed with random content, mixed with corrupted,
// truncated, bad-start, over-long and noise buffers. Runs several phases with
// different start markers and sender/receiver idling. ccfd_frame_checker
// does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_crc_checked_frame_deframer_unit;
   import ccfd_pkg::*;

   localparam int PHASE_ITEMS  = 340;
   localparam int HOLD_AT      = 4;      // frame after which the sender waits
   localparam int DRAIN_CYCLES = 4;
   localparam int END_LIMIT    = 20000;

   typedef enum int {
      FRAME_GOOD,
      FRAME_CRC_BAD,
      FRAME_CUT,
      FRAME_BAD_START,
      FRAME_TRAILING,
      FRAME_LONG_DECL,
      FRAME_END_ON_BODY,
      FRAME_NOISE,
      FRAME_KINDS
   } frame_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       is_end;
   } rx_item_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   int unsigned fail_count;
   int unsigned results_owed;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned frames_sent    = 0;
   logic [7:0]  marker_now     = START_MARKER_RESET;
   rx_item_type tx_q[$];

   ccfd_req_if req_chan();
   ccfd_rsp_if rsp_chan();

   always #4 clock = ~clock;

   crc_checked_frame_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   ccfd_frame_checker frame_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Frame check sequence for building good frames
   function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      c = acc ^ {8'h00, d};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Build one buffer: marker, header, body, check bytes, extras, then cut
   task automatic queue_frame(input logic [7:0] first, input logic [15:0] blen,
                              input int nbody, input int fill, input logic [7:0] fcs_flip,
                              input int extra, input int cut);
      logic [7:0]  frame_bytes[$];
      logic [15:0] fcs;
      int          len;
      frame_bytes.push_back(first);
      repeat (HDR_DEPTH) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      frame_bytes.push_back(blen[15:8]);
      frame_bytes.push_back(blen[7:0]);
      repeat (nbody) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      fcs = CRC_INIT;
      for (int i = 1; i < frame_bytes.size(); i++) fcs = fcs_update(fcs, frame_bytes[i]);
      fcs = ~fcs;
      frame_bytes.push_back(fcs[7:0] ^ fcs_flip);
      frame_bytes.push_back(fcs[15:8]);
      repeat (extra) frame_bytes.push_back(8'($urandom));
      len = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < len; i++) tx_q.push_back('{frame_bytes[i], i == len - 1});
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      if (frames_sent < FRAME_KINDS) return frame_kind_type'(frames_sent);
      r = $urandom_range(99);
      if (r < 55) return FRAME_GOOD;
      if (r < 65) return FRAME_CRC_BAD;
      if (r < 73) return FRAME_CUT;
      if (r < 80) return FRAME_BAD_START;
      if (r < 87) return FRAME_TRAILING;
      if (r < 91) return FRAME_LONG_DECL;
      if (r < 95) return FRAME_END_ON_BODY;
      return FRAME_NOISE;
   endfunction

   task automatic queue_random_buffer(input frame_kind_type kind);
      logic [15:0] blen;
      logic [7:0]  first;
      logic [7:0]  flip;
      int          nbody;
      int          extra;
      int          cut;
      int          n;
      // mostly short bodies, now and then a longer one
      blen  = ($urandom_range(19) == 0) ? 16'($urandom_range(300, 25))
                                        : 16'($urandom_range(24));
      first = marker_now;
      flip  = 8'h00;
      extra = 0;
      cut   = 0;
      nbody = blen;
      case (kind)
         FRAME_CRC_BAD:   flip = 8'($urandom_range(255, 1));
         FRAME_CUT:       cut = $urandom_range(blen + 17, 1);
         FRAME_BAD_START: first = marker_now ^ 8'($urandom_range(255, 1));
         FRAME_TRAILING:  extra = $urandom_range(6, 1);
         FRAME_LONG_DECL: begin
            blen  = 16'hFFFF;
            nbody = $urandom_range(20);
         end
         FRAME_END_ON_BODY: begin
            if (blen == 0) blen = 16'd1;
            nbody = blen;
            cut   = HEADER_BYTES + $urandom_range(blen, 1);
         end
         default: ;
      endcase
      if (kind == FRAME_NOISE) begin
         n = $urandom_range(40, 1);
         for (int i = 0; i < n; i++) tx_q.push_back('{8'($urandom), i == n - 1});
      end else begin
         queue_frame(first, blen, nbody, -1, flip, extra, cut);
      end
      frames_sent++;
   endtask

   // Drive the queued bytes, idling at random between items
   task automatic send_buffer();
      rx_item_type it;
      while (tx_q.size() != 0) begin
         it = tx_q.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
         req_chan.valid      = 1'b1;
         req_chan.rx_byte    = it.data;
         req_chan.buffer_end = it.is_end;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         @(negedge clock);
      end
      req_chan.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_marker(input logic [7:0] value);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      marker_now  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Main stimulus
   initial begin
      logic [7:0] phase_marker [4];
      int         phase_send [4];
      int         phase_recv [4];
      int         items;
      int         frames;
      int         guard;
      phase_marker = '{8'h00, 8'hFF, 8'($urandom), START_MARKER_RESET};
      phase_send   = '{0, 74, 0, 8};
      phase_recv   = '{0, 0, 74, 8};

      req_chan.valid      = 1'b0;
      req_chan.rx_byte    = 8'h00;
      req_chan.buffer_end = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one-byte buffer, all-ones header fields with empty body, short noise
      tx_q.push_back('{8'hFF, 1'b1});
      queue_frame(marker_now, 16'h0000, 0, 255, 8'h00, 0, 0);
      for (int i = 0; i < 3; i++) tx_q.push_back('{8'h00, i == 2});
      send_buffer();

      // Random phases, each under its own start marker and idling
      for (int p = 0; p < 4; p++) begin
         write_marker(phase_marker[p]);
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         items  = 0;
         frames = 0;
         while (items < PHASE_ITEMS) begin
            queue_random_buffer(pick_kind());
            items += tx_q.size();
            send_buffer();
            frames++;
            if (frames == HOLD_AT) wait_drained();
         end
      end

      // Drain and give the verdict
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      guard = 0;
      while (results_owed != 0 && guard < END_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("[crc_checked_frame_deframer_unit] OK");
      end else begin
         $display("[crc_checked_frame_deframer_unit] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("[crc_checked_frame_deframer_unit] ERROR");
      $finish;
   end

endmodule

[crc_checked_frame_deframer_unit.f]
design/ccfd_pkg.sv
design/ccfd_if.sv
design/crc_checked_frame_deframer_unit.sv
dv/ccfd_frame_checker.sv
dv/tb_crc_checked_frame_deframer_unit.sv
